FILE: src/rct_pkg.sv
// Shared types, codes and decode helpers for the register constant tracker.
package rct_pkg;

	localparam logic [2:0] OP_MOV  = 3'd0;
	localparam logic [2:0] OP_PUSH = 3'd1;
	localparam logic [2:0] OP_ADD  = 3'd2;
	localparam logic [2:0] OP_SUB  = 3'd3;
	localparam logic [2:0] OP_XOR  = 3'd4;

	localparam logic [1:0] SRC_REG = 2'd0;
	localparam logic [1:0] SRC_IMM = 2'd1;

	localparam logic [4:0] NUM_REGS     = 5'd20;
	localparam logic [4:0] FIRST_HI     = 5'd4;
	localparam logic [4:0] FIRST_WORD   = 5'd8;
	localparam logic [4:0] FIRST_SEG    = 5'd12;
	localparam logic [15:0] SP_FLAG     = 16'h0100;
	localparam int          NUM_ENTRIES = 12;

	typedef logic [3:0] entry_idx_t;

	typedef enum logic [1:0] {
		PART_LO   = 2'd0,
		PART_HI   = 2'd1,
		PART_WORD = 2'd2
	} part_t;

	typedef enum logic [2:0] {
		ACT_NONE      = 3'd0,
		ACT_MOV       = 3'd1,
		ACT_ADD       = 3'd2,
		ACT_SUB       = 3'd3,
		ACT_ZERO      = 3'd4,
		ACT_FORGET    = 3'd5,
		ACT_FORGET_SP = 3'd6,
		ACT_CLEAR     = 3'd7
	} act_t;

	typedef struct packed {
		logic [15:0] mask;
		entry_idx_t  idx;
		part_t       part;
	} reg_loc_t;

	typedef struct packed {
		act_t        act;
		logic        dreg_ok;
		reg_loc_t    dst;
		logic        src_is_imm;
		reg_loc_t    src;
		logic [15:0] imm;
	} dec_item_t;

	typedef struct packed {
		logic valid_s1;
		logic exec;
	} back_stat_t;

	function automatic reg_loc_t reg_locate(input logic [4:0] r);
		reg_loc_t   loc;
		logic [4:0] off;
		loc.mask = 16'h0000;
		loc.idx  = '0;
		loc.part = PART_WORD;
		off      = 5'd0;
		if (r < FIRST_HI) begin
			loc.mask = 16'h0001 << r[3:0];
			loc.idx  = r[3:0];
			loc.part = PART_LO;
		end else if (r < FIRST_WORD) begin
			off      = r - FIRST_HI;
			loc.mask = 16'h0001 << r[3:0];
			loc.idx  = off[3:0];
			loc.part = PART_HI;
		end else if (r < FIRST_SEG) begin
			off      = r - FIRST_WORD;
			loc.mask = (16'h0001 << off[3:0]) | (16'h0010 << off[3:0]);
			loc.idx  = off[3:0];
		end else if (r < NUM_REGS) begin
			off      = r - FIRST_HI;
			loc.mask = 16'h0001 << off[3:0];
			off      = r - FIRST_WORD;
			loc.idx  = off[3:0];
		end
		return loc;
	endfunction

endpackage

FILE: src/rct_front.sv
// Front end: unpacks and classifies each decoded instruction.
module rct_front
	import rct_pkg::*;
(
	input  logic [31:0] tdata,
	output dec_item_t   item
);

	logic [2:0]  op;
	logic        dst_is_reg;
	logic [4:0]  dst_reg;
	logic [1:0]  src_kind;
	logic [4:0]  src_reg;
	logic        dreg_ok;
	logic        same;

	assign op         = tdata[2:0];
	assign dst_is_reg = tdata[3];
	assign dst_reg    = tdata[8:4];
	assign src_kind   = tdata[10:9];
	assign src_reg    = tdata[15:11];

	assign dreg_ok = dst_is_reg && (dst_reg < NUM_REGS);
	assign same    = (src_kind == SRC_REG) && (src_reg == dst_reg);

	always_comb begin
		item            = '0;
		item.dreg_ok    = dreg_ok;
		item.dst        = reg_locate(dst_reg);
		item.src_is_imm = (src_kind == SRC_IMM);
		item.imm        = tdata[31:16];
		if (src_kind == SRC_REG) begin
			item.src = reg_locate(src_reg);
		end
		unique case (op)
			OP_MOV:  item.act = dreg_ok ? ACT_MOV : ACT_NONE;
			OP_PUSH: item.act = ACT_FORGET_SP;
			OP_ADD:  item.act = dreg_ok ? ACT_ADD : ACT_NONE;
			OP_SUB:  item.act = !dreg_ok ? ACT_NONE : (same ? ACT_ZERO : ACT_SUB);
			OP_XOR:  item.act = !dreg_ok ? ACT_NONE : (same ? ACT_ZERO : ACT_FORGET);
			default: item.act = ACT_CLEAR;
		endcase
	end

endmodule

FILE: src/rct_queue.sv
// Two-entry queue of classified instructions between front and back.
module rct_queue
	import rct_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  dec_item_t push_item,
	output logic      ready,
	input  logic      pop,
	output logic      head_valid,
	output dec_item_t head_item
);

	dec_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign ready      = (count_q != 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: src/rct_back.sv
// Back end: value memory read, flag update and arithmetic, output register.
module rct_back
	import rct_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  dec_item_t  head_item,
	output logic       pop,
	output back_stat_t stat,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       out_known,
	output logic [15:0] out_value
);

	logic [15:0] mem_q [NUM_ENTRIES];

	dec_item_t   item_s1;
	logic        valid_s1;
	logic [15:0] rd_dst_s1;
	logic [15:0] rd_src_s1;

	logic [15:0] flags_q;
	logic        wr_vld_q;
	entry_idx_t  wr_addr_q;
	logic [15:0] wr_data_q;
	logic [1:0]  wr_be_q;

	logic        out_valid_q;
	logic        out_known_q;
	logic [15:0] out_value_q;

	logic        exec;
	logic [15:0] dst_word;
	logic [15:0] src_word;
	logic [15:0] a_val;
	logic [15:0] b_val;
	logic        d_known;
	logic        s_known;
	logic        do_set;
	logic        do_forget;
	logic [15:0] res;
	logic [15:0] res_trunc;
	logic [15:0] flags_new;
	logic        known_new;
	logic [15:0] wr_data;
	logic [1:0]  wr_be;

	function automatic logic [15:0] bypass(input logic [15:0] rd, input entry_idx_t addr,
		input logic vld, input entry_idx_t waddr, input logic [15:0] wdata,
		input logic [1:0] be);
		logic [15:0] w;
		w = rd;
		if (vld && (waddr == addr)) begin
			if (be[0]) begin
				w[7:0] = wdata[7:0];
			end
			if (be[1]) begin
				w[15:8] = wdata[15:8];
			end
		end
		return w;
	endfunction

	function automatic logic [15:0] extract(input logic [15:0] w, input part_t part);
		logic [15:0] v;
		unique case (part)
			PART_LO: v = {8'h00, w[7:0]};
			PART_HI: v = {8'h00, w[15:8]};
			default: v = w;
		endcase
		return v;
	endfunction

	function automatic logic is_known(input logic [15:0] f, input logic [15:0] m);
		return (m != 16'h0000) && ((f & m) == m);
	endfunction

	assign exec = valid_s1 && (!out_valid_q || out_ready);
	assign pop  = head_valid && (!valid_s1 || exec);

	assign stat.valid_s1 = valid_s1;
	assign stat.exec     = exec;

	assign dst_word = bypass(rd_dst_s1, item_s1.dst.idx, wr_vld_q, wr_addr_q, wr_data_q, wr_be_q);
	assign src_word = bypass(rd_src_s1, item_s1.src.idx, wr_vld_q, wr_addr_q, wr_data_q, wr_be_q);
	assign a_val    = extract(dst_word, item_s1.dst.part);
	assign b_val    = item_s1.src_is_imm ? item_s1.imm : extract(src_word, item_s1.src.part);
	assign d_known  = is_known(flags_q, item_s1.dst.mask);
	assign s_known  = item_s1.src_is_imm || is_known(flags_q, item_s1.src.mask);

	always_comb begin
		do_set    = 1'b0;
		do_forget = 1'b0;
		res       = 16'h0000;
		flags_new = flags_q;
		unique case (item_s1.act)
			ACT_MOV: begin
				do_set    = s_known;
				do_forget = !s_known;
				res       = b_val;
			end
			ACT_ADD: begin
				do_set    = d_known && s_known;
				do_forget = !(d_known && s_known);
				res       = a_val + b_val;
			end
			ACT_SUB: begin
				do_set    = d_known && s_known;
				do_forget = !(d_known && s_known);
				res       = a_val - b_val;
			end
			ACT_ZERO: begin
				do_set = 1'b1;
			end
			ACT_FORGET: begin
				do_forget = 1'b1;
			end
			ACT_FORGET_SP: begin
				flags_new = flags_q & ~SP_FLAG;
			end
			ACT_CLEAR: begin
				flags_new = 16'h0000;
			end
			default: begin
			end
		endcase
		if (do_set) begin
			flags_new = flags_q | item_s1.dst.mask;
		end else if (do_forget) begin
			flags_new = flags_q & ~item_s1.dst.mask;
		end
	end

	assign res_trunc = (item_s1.dst.part == PART_WORD) ? res : {8'h00, res[7:0]};
	assign known_new = item_s1.dreg_ok && is_known(flags_new, item_s1.dst.mask);

	always_comb begin
		unique case (item_s1.dst.part)
			PART_LO: begin
				wr_data = {8'h00, res[7:0]};
				wr_be   = 2'b01;
			end
			PART_HI: begin
				wr_data = {res[7:0], 8'h00};
				wr_be   = 2'b10;
			end
			default: begin
				wr_data = res;
				wr_be   = 2'b11;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (exec && do_set) begin
			if (wr_be[0]) begin
				mem_q[item_s1.dst.idx][7:0] <= wr_data[7:0];
			end
			if (wr_be[1]) begin
				mem_q[item_s1.dst.idx][15:8] <= wr_data[15:8];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			rd_dst_s1 <= mem_q[head_item.dst.idx];
			rd_src_s1 <= mem_q[head_item.src.idx];
			item_s1   <= head_item;
		end
		if (exec && do_set) begin
			wr_addr_q <= item_s1.dst.idx;
			wr_data_q <= wr_data;
			wr_be_q   <= wr_be;
		end
		if (exec) begin
			out_known_q <= known_new;
			out_value_q <= known_new ? (do_set ? res_trunc : a_val) : 16'h0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			flags_q     <= 16'h0000;
			wr_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				valid_s1 <= 1'b1;
			end else if (exec) begin
				valid_s1 <= 1'b0;
			end
			if (exec) begin
				flags_q <= flags_new;
			end
			if (exec && do_set) begin
				wr_vld_q <= 1'b1;
			end
			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_known = out_known_q;
	assign out_value = out_value_q;

endmodule

FILE: src/x86_register_constant_tracker_core.sv
// Top level of the x86 register constant tracker.
// Takes one decoded instruction per clock and returns one result per instruction, in order:
// whether the destination register holds a known constant afterwards, and its value (zero
// when unknown). Sustained rate is one instruction per cycle while the output is not
// stalled. Each result passes through the queue, the execute stage and the output register.
// A two-entry queue absorbs output stalls, and the input stalls once it is full. The rate is
// set by the execute stage, which reads and updates the known flags and writes the value
// memory in that stage, with the last write forwarded around the registered memory read.
module x86_register_constant_tracker_core
	import rct_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// op[2:0], dst_is_reg[3], dst_reg[8:4], src_kind[10:9], src_reg[15:11], src_imm[31:16]
	input  logic [31:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// dst_known[0], dst_value[16:1], zero[23:17]
	output logic [23:0] m_axis_tdata
);

	dec_item_t   front_item;
	dec_item_t   head_item;
	logic        head_valid;
	logic        pop;
	back_stat_t  stat;
	logic        out_known;
	logic [15:0] out_value;

	rct_front u_front (
		.tdata (s_axis_tdata),
		.item  (front_item)
	);

	rct_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (s_axis_tvalid && s_axis_tready),
		.push_item  (front_item),
		.ready      (s_axis_tready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_item  (head_item)
	);

	rct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (pop),
		.stat       (stat),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_known  (out_known),
		.out_value  (out_value)
	);

	assign m_axis_tdata = {7'b0000000, out_value, out_known};

	a_unknown_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == 16'h0000)
		else $error("unknown result carries a nonzero value");

	a_stall_holds_exec: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |-> !stat.exec)
		else $error("execute stage advanced into a stalled output");

	a_stall_holds_pop: assert property (@(posedge clk) disable iff (!arst_n)
		stat.valid_s1 && m_axis_tvalid && !m_axis_tready |-> !pop)
		else $error("queue popped into an occupied execute stage");

	a_pop_fills_stage: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> stat.valid_s1)
		else $error("popped item did not reach the execute stage");

endmodule
